[hw/rtl/assert_macros.svh]
// Assertion macros used by the top RTL file of the column sum core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge of clk outside reset
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition implies another in the next cycle
`define ASSERT_NEXT(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error(msg);

`endif

[hw/rtl/dfds_pkg.sv]
// Types and constants shared by the delimited field decimal sum core
package dfds_pkg;

	// Parse phase of the back end
	typedef enum logic [1:0] {
		PH_SEEK   = 2'd0,
		PH_DIGITS = 2'd1,
		PH_SKIP   = 2'd2
	} phase_t;

	// Register indexes on the configuration port
	localparam logic [1:0] REG_FIELD_SEP  = 2'd0;
	localparam logic [1:0] REG_LINE_TERM  = 2'd1;
	localparam logic [1:0] REG_SEP_BEFORE = 2'd2;

	// Register reset values
	localparam logic [7:0] FIELD_SEP_RST  = 8'd124;
	localparam logic [7:0] LINE_TERM_RST  = 8'd10;
	localparam logic [3:0] SEP_BEFORE_RST = 4'd4;

	// ASCII digit range
	localparam logic [7:0] CHAR_ZERO = 8'h30;
	localparam logic [7:0] CHAR_NINE = 8'h39;

	localparam int APB_ADDR_W = 4;
	localparam int APB_DATA_W = 32;

	// Configuration register set
	typedef struct packed {
		logic [7:0] field_sep;
		logic [7:0] line_term;
		logic [3:0] sep_before;
	} cfg_t;

	// Classified byte passed from front to back
	typedef struct packed {
		logic       is_sep;
		logic       is_term;
		logic       is_digit;
		logic [3:0] digit;
		logic       last;
	} class_t;

	// Finished total on its way to the result queue
	typedef struct packed {
		logic        valid;
		logic [31:0] total;
	} result_t;

endpackage

[hw/rtl/delimited_field_decimal_sum_core.sv]
// A byte is parsed when the back end takes it from the front queue; the stream total is registered after that.
// Throughput: one byte per cycle, set by the parse step in the back end, except while a last byte waits.
// A last byte waits in the front queue only while the result queue has no free slot.
// Reset (arst_n low): parse state, totals and queues clear; registers return to
// separator 124, terminator 10 and four separators before the field.
module delimited_field_decimal_sum_core import dfds_pkg::*; #(
	parameter int IN_DEPTH  = 4,
	parameter int OUT_DEPTH = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  logic [7:0]            data_byte,
	input  logic                  end_of_stream,
	output logic                  empty,
	input  logic                  pop,
	output logic [31:0]           column_total,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready
);
`include "assert_macros.svh"

	localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

	cfg_t                 cfg_q;
	logic                 cfg_wr;
	logic [1:0]           reg_idx;
	logic                 fq_push;
	logic                 fq_pop;
	logic                 fq_full;
	logic                 fq_empty;
	class_t               fq_wr_item;
	class_t               fq_rd_item;
	result_t              res;
	logic                 out_full;
	logic                 out_room;
	logic [OUT_CNT_W-1:0] out_count;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.field_sep  <= FIELD_SEP_RST;
			cfg_q.line_term  <= LINE_TERM_RST;
			cfg_q.sep_before <= SEP_BEFORE_RST;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_FIELD_SEP:  cfg_q.field_sep  <= pwdata[7:0];
				REG_LINE_TERM:  cfg_q.line_term  <= pwdata[7:0];
				REG_SEP_BEFORE: cfg_q.sep_before <= pwdata[3:0];
				default: ;
			endcase
		end
	end

	// Read back configuration registers
	always_comb begin
		unique case (reg_idx)
			REG_FIELD_SEP:  prdata = APB_DATA_W'(cfg_q.field_sep);
			REG_LINE_TERM:  prdata = APB_DATA_W'(cfg_q.line_term);
			REG_SEP_BEFORE: prdata = APB_DATA_W'(cfg_q.sep_before);
			default:        prdata = '0;
		endcase
	end

	dfds_front u_front (
		.push          (push),
		.data_byte     (data_byte),
		.end_of_stream (end_of_stream),
		.cfg           (cfg_q),
		.queue_full    (fq_full),
		.q_push        (fq_push),
		.q_item        (fq_wr_item)
	);

	assign full = fq_full;

	dfds_fifo #(
		.WIDTH ($bits(class_t)),
		.DEPTH (IN_DEPTH)
	) u_class_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (fq_push),
		.wdata  (fq_wr_item),
		.pop    (fq_pop),
		.rdata  (fq_rd_item),
		.full   (fq_full),
		.empty  (fq_empty),
		.count  ()
	);

	// Reserve a result slot for the total already in flight
	assign out_room = ({1'b0, out_count} + (OUT_CNT_W + 1)'(res.valid))
		< (OUT_CNT_W + 1)'(OUT_DEPTH);

	dfds_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.q_empty  (fq_empty),
		.q_item   (fq_rd_item),
		.out_room (out_room),
		.q_pop    (fq_pop),
		.res      (res)
	);

	dfds_fifo #(
		.WIDTH (32),
		.DEPTH (OUT_DEPTH)
	) u_result_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res.valid),
		.wdata  (res.total),
		.pop    (pop),
		.rdata  (column_total),
		.full   (out_full),
		.empty  (empty),
		.count  (out_count)
	);

	// A finished total always finds room in the result queue
	`ASSERT_CLK(a_result_room, !(res.valid && out_full), "result queue overflow")
	// A total follows only from a last byte taken by the back end
	`ASSERT_CLK(a_result_cause, !res.valid || $past(fq_pop && fq_rd_item.last),
		"total without a last byte")
	// Every last byte taken by the back end yields a total
	`ASSERT_NEXT(a_last_total, fq_pop && fq_rd_item.last, res.valid, "last byte lost")
	// The back end never takes from an empty queue
	`ASSERT_CLK(a_pop_nonempty, !(fq_pop && fq_empty), "pop of empty front queue")

endmodule

[hw/rtl/dfds_fifo.sv]
// Small register queue with first-word fall-through read
module dfds_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	input  logic [WIDTH-1:0]             wdata,
	input  logic                         pop,
	output logic [WIDTH-1:0]             rdata,
	output logic                         full,
	output logic                         empty,
	output logic [$clog2(DEPTH+1)-1:0]   count
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign count   = count_q;
	assign rdata   = mem_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	// Store the incoming request
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	// Advance pointers and track the fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (!do_push && do_pop) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

[hw/rtl/dfds_front.sv]
// Front end: accepts stream bytes and classifies them against the configuration
module dfds_front import dfds_pkg::*; (
	input  logic       push,
	input  logic [7:0] data_byte,
	input  logic       end_of_stream,
	input  cfg_t       cfg,
	input  logic       queue_full,
	output logic       q_push,
	output class_t     q_item
);

	// Accept when the queue to the back end has room
	assign q_push = push && !queue_full;

	// Classify the byte
	always_comb begin
		q_item.is_sep   = (data_byte == cfg.field_sep);
		q_item.is_term  = (data_byte == cfg.line_term);
		q_item.is_digit = (data_byte >= CHAR_ZERO) && (data_byte <= CHAR_NINE);
		q_item.digit    = 4'(data_byte - CHAR_ZERO);
		q_item.last     = end_of_stream;
	end

endmodule

[hw/rtl/dfds_back.sv]
// Back end: runs the parse state machine and forms the stream total
module dfds_back import dfds_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_t    cfg,
	input  logic    q_empty,
	input  class_t  q_item,
	input  logic    out_room,
	output logic    q_pop,
	output result_t res
);

	phase_t      phase_q, phase_n;
	logic [3:0]  seen_q, seen_n;
	logic [31:0] value_q, value_n;
	logic [31:0] total_q, total_n;
	logic [31:0] base_s1;
	logic [31:0] pend_s1;
	logic        valid_s1;
	logic [4:0]  seen_inc;

	// Hold a last byte until the result queue has a free slot
	assign q_pop    = !q_empty && (!q_item.last || out_room);
	assign seen_inc = {1'b0, seen_q} + 5'd1;

	// Next parse state for the byte at the head of the queue
	always_comb begin
		phase_n = phase_q;
		seen_n  = seen_q;
		value_n = value_q;
		total_n = total_q;
		unique case (phase_q)
			PH_SEEK: begin
				if (q_item.is_sep) begin
					if (seen_inc >= {1'b0, cfg.sep_before}) begin
						phase_n = PH_DIGITS;
						seen_n  = '0;
						value_n = '0;
					end else begin
						seen_n = seen_inc[3:0];
					end
				end
			end
			PH_DIGITS: begin
				if (q_item.is_digit) begin
					value_n = (value_q << 3) + (value_q << 1) + 32'(q_item.digit);
				end else begin
					total_n = total_q + value_q;
					value_n = '0;
					phase_n = q_item.is_term ? PH_SEEK : PH_SKIP;
				end
			end
			default: begin
				if (q_item.is_term) begin
					phase_n = PH_SEEK;
				end
			end
		endcase
	end

	// Advance state; clear it after the last byte of a stream
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_SEEK;
			seen_q   <= '0;
			value_q  <= '0;
			total_q  <= '0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= q_pop && q_item.last;
			if (q_pop) begin
				if (q_item.last) begin
					phase_q <= PH_SEEK;
					seen_q  <= '0;
					value_q <= '0;
					total_q <= '0;
				end else begin
					phase_q <= phase_n;
					seen_q  <= seen_n;
					value_q <= value_n;
					total_q <= total_n;
				end
			end
		end
	end

	// Capture the total and any pending field value
	always_ff @(posedge clk) begin
		if (q_pop && q_item.last) begin
			base_s1 <= total_n;
			pend_s1 <= (phase_n == PH_DIGITS) ? value_n : '0;
		end
	end

	assign res.valid = valid_s1;
	assign res.total = base_s1 + pend_s1;

endmodule
